/* src/extension_record_stream_validator_core_assert.svh */
// assertion macros used by the checker file of the record stream validator
// depends on: nothing; each macro expands to one labeled concurrent assertion
`ifndef EXTENSION_RECORD_STREAM_VALIDATOR_CORE_ASSERT_SVH
`define EXTENSION_RECORD_STREAM_VALIDATOR_CORE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define ERV_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define ERV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/erv_pkg.sv */
// shared types, limits and reason codes of the record stream validator
// depends on: nothing
package erv_pkg;

    // limits
    localparam int unsigned MAX_FIELD_BYTES   = 512;
    localparam int unsigned MAX_EXTENSIONS    = 256;
    localparam int unsigned MAX_CAPABILITIES  = 128;
    localparam int unsigned MAX_MESSAGE_BYTES = 256 * 1024;
    localparam int unsigned COUNT_SAT         = 511;

    localparam int unsigned LEN_W = 19;

    // reject reasons
    localparam logic [3:0] REASON_OK        = 4'd0;
    localparam logic [3:0] REASON_TRUNCATED = 4'd1;
    localparam logic [3:0] REASON_TOO_LONG  = 4'd2;
    localparam logic [3:0] REASON_COUNT     = 4'd3;
    localparam logic [3:0] REASON_TOKEN     = 4'd4;
    localparam logic [3:0] REASON_KIND      = 4'd5;
    localparam logic [3:0] REASON_VERSION   = 4'd6;
    localparam logic [3:0] REASON_TRAILING  = 4'd7;
    localparam logic [3:0] REASON_OVERSIZE  = 4'd8;

    localparam logic [7:0] MAX_KIND   = 8'd4;
    localparam logic [7:0] MAX_POLICY = 8'd2;

    // one input request held in the input register
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       last;
    } erv_byte_t;

    // one verdict
    typedef struct packed {
        logic        accepted;
        logic [3:0]  reason;
        logic [31:0] version;
        logic [8:0]  total;
    } erv_result_t;

    // allowed string character: letters, digits, dot, underscore, dash
    function automatic logic token_char(input logic [7:0] c);
        token_char = (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) ||
                     (c >= 8'h30 && c <= 8'h39) || c == 8'h2e || c == 8'h5f ||
                     c == 8'h2d;
    endfunction

    localparam logic [7:0] CHAR_COLON = 8'h3a;

endpackage

/* src/erv_in_reg.sv */
// input register of the record stream validator: takes one byte per request
// depends on: erv_pkg
module erv_in_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        data_byte,
    input  logic              last_byte,
    input  logic              advance,
    output erv_pkg::erv_byte_t held
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;
    logic       last_reg;
    logic       take;

    // full and not draining this cycle
    assign in_stall = valid_reg && !advance;
    assign take     = in_valid && !in_stall;

    always_comb
    begin
        if (take)
            valid_next = 1'b1;
        else if (advance)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg <= data_byte;
            last_reg <= last_byte;
        end
    end

    assign held.valid = valid_reg;
    assign held.data  = data_reg;
    assign held.last  = last_reg;

endmodule

/* src/erv_parser.sv */
// parse engine: per-byte state update and verdict on the last byte
// depends on: erv_pkg
module erv_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  erv_pkg::erv_byte_t  held,
    input  logic [31:0]         expected_version,
    output erv_pkg::erv_result_t result
);

    typedef enum logic [3:0] {
        PH_VER      = 4'd0,
        PH_CNT      = 4'd1,
        PH_ID_LEN   = 4'd2,
        PH_ID_BODY  = 4'd3,
        PH_VV_LEN   = 4'd4,
        PH_VV_BODY  = 4'd5,
        PH_FP_LEN   = 4'd6,
        PH_FP_BODY  = 4'd7,
        PH_KIND     = 4'd8,
        PH_POLICY   = 4'd9,
        PH_CAP_CNT  = 4'd10,
        PH_CAP_LEN  = 4'd11,
        PH_CAP_BODY = 4'd12,
        PH_END      = 4'd13,
        PH_FAIL     = 4'd14
    } phase_t;

    localparam logic [erv_pkg::LEN_W-1:0] LEN_MAX = erv_pkg::LEN_W'(erv_pkg::MAX_MESSAGE_BYTES);

    phase_t                    phase_reg, phase_next;
    logic [31:0]               acc_reg, acc_next;
    logic [1:0]                idx_reg, idx_next;
    logic [9:0]                str_reg, str_next;
    logic [8:0]                ext_reg, ext_next;
    logic [7:0]                cap_reg, cap_next;
    logic [erv_pkg::LEN_W-1:0] len_reg, len_next;
    logic [3:0]                fail_reg, fail_next;
    logic [31:0]               ver_reg, ver_next;
    logic [8:0]                cnt_reg, cnt_next;

    logic [31:0] word;
    logic [8:0]  ext_dec;
    logic [7:0]  cap_dec;
    logic [9:0]  str_dec;
    logic        str_done;
    phase_t      done_body;
    logic        char_ok;
    logic [3:0]  reason;

    // assembled little-endian word including this byte
    assign word = acc_reg | ({24'd0, held.data} << {idx_reg, 3'b000});
    assign ext_dec = ext_reg - 9'd1;
    assign cap_dec = cap_reg - 8'd1;
    assign str_dec = str_reg - 10'd1;
    assign char_ok = erv_pkg::token_char(held.data) ||
                     (phase_reg == PH_FP_BODY && held.data == erv_pkg::CHAR_COLON);

    // next state for one byte
    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        idx_next   = idx_reg;
        str_next   = str_reg;
        ext_next   = ext_reg;
        cap_next   = cap_reg;
        fail_next  = fail_reg;
        ver_next   = ver_reg;
        cnt_next   = cnt_reg;
        str_done   = 1'b0;
        done_body  = PH_ID_BODY;
        reason     = erv_pkg::REASON_OK;

        // size counter saturates one past the limit
        len_next = (len_reg <= LEN_MAX) ? len_reg + 1'b1 : len_reg;

        unique case (phase_reg)
            PH_FAIL:
            begin
            end
            PH_END:
            begin
                fail_next  = erv_pkg::REASON_TRAILING;
                phase_next = PH_FAIL;
            end
            PH_KIND:
            begin
                if (held.data > erv_pkg::MAX_KIND && fail_reg == erv_pkg::REASON_OK)
                    fail_next = erv_pkg::REASON_KIND;
                phase_next = PH_POLICY;
            end
            PH_POLICY:
            begin
                if (held.data > erv_pkg::MAX_POLICY && fail_reg == erv_pkg::REASON_OK)
                    fail_next = erv_pkg::REASON_KIND;
                phase_next = PH_CAP_CNT;
                acc_next   = 32'd0;
                idx_next   = 2'd0;
            end
            PH_ID_BODY, PH_VV_BODY, PH_FP_BODY, PH_CAP_BODY:
            begin
                if (!char_ok && fail_reg == erv_pkg::REASON_OK)
                    fail_next = erv_pkg::REASON_TOKEN;
                str_next = str_dec;
                if (str_dec == 10'd0)
                begin
                    str_done  = 1'b1;
                    done_body = phase_reg;
                end
            end
            default:
            begin
                // word phases: version, counts, lengths
                acc_next = word;
                idx_next = idx_reg + 2'd1;
                if (idx_reg == 2'd3)
                begin
                    acc_next = 32'd0;
                    idx_next = 2'd0;
                    unique case (phase_reg)
                        PH_VER:
                        begin
                            ver_next = word;
                            if (word != expected_version && fail_reg == erv_pkg::REASON_OK)
                                fail_next = erv_pkg::REASON_VERSION;
                            phase_next = PH_CNT;
                        end
                        PH_CNT:
                        begin
                            cnt_next = (word > 32'(erv_pkg::COUNT_SAT)) ?
                                       9'(erv_pkg::COUNT_SAT) : word[8:0];
                            if (word > 32'(erv_pkg::MAX_EXTENSIONS))
                            begin
                                fail_next  = erv_pkg::REASON_COUNT;
                                phase_next = PH_FAIL;
                            end
                            else
                            begin
                                ext_next   = word[8:0];
                                phase_next = (word != 32'd0) ? PH_ID_LEN : PH_END;
                            end
                        end
                        PH_CAP_CNT:
                        begin
                            if (word > 32'(erv_pkg::MAX_CAPABILITIES))
                            begin
                                fail_next  = erv_pkg::REASON_COUNT;
                                phase_next = PH_FAIL;
                            end
                            else if (word != 32'd0)
                            begin
                                cap_next   = word[7:0];
                                phase_next = PH_CAP_LEN;
                            end
                            else
                            begin
                                // extension with no capabilities ends here
                                cap_next   = 8'd0;
                                ext_next   = ext_dec;
                                phase_next = (ext_dec != 9'd0) ? PH_ID_LEN : PH_END;
                            end
                        end
                        PH_ID_LEN, PH_VV_LEN, PH_FP_LEN, PH_CAP_LEN:
                        begin
                            if (word > 32'(erv_pkg::MAX_FIELD_BYTES))
                            begin
                                fail_next  = erv_pkg::REASON_TOO_LONG;
                                phase_next = PH_FAIL;
                            end
                            else if (word == 32'd0)
                            begin
                                // empty string counts as a bad token
                                if (fail_reg == erv_pkg::REASON_OK)
                                    fail_next = erv_pkg::REASON_TOKEN;
                                str_done  = 1'b1;
                                done_body = phase_t'(phase_reg + 4'd1);
                            end
                            else
                            begin
                                str_next   = word[9:0];
                                phase_next = phase_t'(phase_reg + 4'd1);
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
        endcase

        // step past a finished string
        if (str_done)
        begin
            unique case (done_body)
                PH_ID_BODY: phase_next = PH_VV_LEN;
                PH_VV_BODY: phase_next = PH_FP_LEN;
                PH_FP_BODY: phase_next = PH_KIND;
                default:
                begin
                    cap_next = cap_dec;
                    if (cap_dec != 8'd0)
                        phase_next = PH_CAP_LEN;
                    else
                    begin
                        ext_next   = ext_dec;
                        phase_next = (ext_dec != 9'd0) ? PH_ID_LEN : PH_END;
                    end
                end
            endcase
        end

        // verdict on the last byte
        if (len_next > LEN_MAX)
            reason = erv_pkg::REASON_OVERSIZE;
        else if (phase_next != PH_END && phase_next != PH_FAIL)
            reason = erv_pkg::REASON_TRUNCATED;
        else
            reason = fail_next;

        result.accepted = (reason == erv_pkg::REASON_OK);
        result.reason   = reason;
        result.version  = ver_next;
        result.total    = cnt_next;

        // message done: back to the header
        if (held.last)
        begin
            phase_next = PH_VER;
            acc_next   = 32'd0;
            idx_next   = 2'd0;
            str_next   = 10'd0;
            ext_next   = 9'd0;
            cap_next   = 8'd0;
            len_next   = '0;
            fail_next  = erv_pkg::REASON_OK;
            ver_next   = 32'd0;
            cnt_next   = 9'd0;
        end
    end

    // parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_VER;
            acc_reg   <= 32'd0;
            idx_reg   <= 2'd0;
            str_reg   <= 10'd0;
            ext_reg   <= 9'd0;
            cap_reg   <= 8'd0;
            len_reg   <= '0;
            fail_reg  <= erv_pkg::REASON_OK;
            ver_reg   <= 32'd0;
            cnt_reg   <= 9'd0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            idx_reg   <= idx_next;
            str_reg   <= str_next;
            ext_reg   <= ext_next;
            cap_reg   <= cap_next;
            len_reg   <= len_next;
            fail_reg  <= fail_next;
            ver_reg   <= ver_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

/* src/erv_out_reg.sv */
// result register of the record stream validator
// depends on: erv_pkg
module erv_out_reg (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  erv_pkg::erv_result_t result,
    output logic                 free,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 accepted,
    output logic [3:0]           reject_reason,
    output logic [31:0]          message_version,
    output logic [8:0]           extension_total
);

    logic                 valid_reg;
    logic                 valid_next;
    erv_pkg::erv_result_t data_reg;

    // empty, or emptied at this edge
    assign free = !valid_reg || !out_stall;

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (!out_stall)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= result;
    end

    assign out_valid       = valid_reg;
    assign accepted        = data_reg.accepted;
    assign reject_reason   = data_reg.reason;
    assign message_version = data_reg.version;
    assign extension_total = data_reg.total;

endmodule

/* src/extension_record_stream_validator_core.sv */
// top level of the extension record stream validator
// depends on: erv_pkg, erv_in_reg, erv_parser, erv_out_reg
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------------
//  input    | in_valid / in_stall  | data_byte, last_byte
//  output   | out_valid / out_stall| accepted, reject_reason, message_version,
//           |                      | extension_total
//  config   | cfg_wr_en            | cfg_wr_data (expected version)
//
// one byte per cycle sustained unless a last byte waits on a busy result register; a
// byte is held in the input register and parsed by combinational logic into the
// parse state and the result register, which drives the verdict on the outputs.
// reset clears the parse state and both stage valid bits; expected version resets to 1.
// a waiting verdict stalls only last bytes; other bytes keep flowing past it.
module extension_record_stream_validator_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        accepted,
    output logic [3:0]  reject_reason,
    output logic [31:0] message_version,
    output logic [8:0]  extension_total
);

    erv_pkg::erv_byte_t   held;
    erv_pkg::erv_result_t result;
    logic                 advance;
    logic                 out_free;
    logic [31:0]          expver_reg;

    // expected version register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            expver_reg <= 32'd1;
        else if (cfg_wr_en)
            expver_reg <= cfg_wr_data;
    end

    // a byte moves on unless it is a last byte and the result slot is busy
    assign advance = held.valid && (!held.last || out_free);

    erv_in_reg u_in (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .advance   (advance),
        .held      (held)
    );

    erv_parser u_parse (
        .clk              (clk),
        .rst_n            (rst_n),
        .advance          (advance),
        .held             (held),
        .expected_version (expver_reg),
        .result           (result)
    );

    erv_out_reg u_out (
        .clk             (clk),
        .rst_n           (rst_n),
        .load            (advance && held.last),
        .result          (result),
        .free            (out_free),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .accepted        (accepted),
        .reject_reason   (reject_reason),
        .message_version (message_version),
        .extension_total (extension_total)
    );

endmodule

/* src/erv_checker.sv */
// port-level checks of the record stream validator, bound to the top level
// depends on: erv_pkg, extension_record_stream_validator_core_assert.svh
`include "extension_record_stream_validator_core_assert.svh"

module erv_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic        accepted,
    input logic [3:0]  reject_reason,
    input logic [31:0] message_version,
    input logic [8:0]  extension_total
);

    // verdict flag agrees with the reason code
    `ERV_ASSERT_NOW(a_accept_matches_reason, clk, rst_n, out_valid,
        accepted == (reject_reason == erv_pkg::REASON_OK),
        "accepted disagrees with reject_reason")

    // reason code stays within the defined set
    `ERV_ASSERT_NOW(a_reason_range, clk, rst_n, out_valid,
        reject_reason <= erv_pkg::REASON_OVERSIZE, "reject_reason out of range")

    // an accepted message never carries more extensions than the limit
    `ERV_ASSERT_NOW(a_accept_count_limit, clk, rst_n, out_valid && accepted,
        extension_total <= 9'(erv_pkg::MAX_EXTENSIONS), "accepted message over extension limit")

    // a stalled verdict stays valid and holds its reason and version
    `ERV_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(reject_reason) && $stable(message_version),
        "stalled verdict changed")

endmodule

bind extension_record_stream_validator_core erv_checker u_erv_checker (.*);
